// File: design/fdlm_pkg.sv
// ----------------------------------------------------------------------------
// fdlm_pkg - shared types, constants and helpers of the feedback delay mixer
// Holds the control word layout, the microprogram and the fixed-point helpers.
// ----------------------------------------------------------------------------
package fdlm_pkg;

	localparam int unsigned DEPTH_DEF = 65536;
	localparam int unsigned SW        = 16;    // sample width
	localparam int unsigned CFW       = 17;    // coefficient width, Q1.16
	localparam int unsigned CFG_IW    = 8;     // register index width
	localparam int unsigned CFG_DW    = 17;    // register data width
	localparam int unsigned STEP_W    = 3;

	localparam logic [CFW-1:0] COEF_ONE = 17'd65536;
	localparam logic [CFW-1:0] COEF_RST = 17'd32768;
	localparam int unsigned    DLY_RST  = 24000;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_DELAY = 8'd0;
	localparam logic [CFG_IW-1:0] REG_FB    = 8'd1;
	localparam logic [CFG_IW-1:0] REG_GAIN  = 8'd2;
	localparam logic [CFG_IW-1:0] REG_MIX   = 8'd3;

	// step conditions
	localparam logic [1:0] COND_NONE = 2'd0;
	localparam logic [1:0] COND_IN   = 2'd1;
	localparam logic [1:0] COND_OUT  = 2'd2;

	// multiplier operand pairs
	localparam logic [1:0] MUL_MIX_X    = 2'd0;
	localparam logic [1:0] MUL_GAIN_DLY = 2'd1;
	localparam logic [1:0] MUL_COMP_SCL = 2'd2;
	localparam logic [1:0] MUL_FB_Y     = 2'd3;

	// program steps
	localparam logic [STEP_W-1:0] ST_ACCEPT = 3'd0;
	localparam logic [STEP_W-1:0] ST_MIX_X  = 3'd1;
	localparam logic [STEP_W-1:0] ST_GAIN   = 3'd2;
	localparam logic [STEP_W-1:0] ST_COMP   = 3'd3;
	localparam logic [STEP_W-1:0] ST_SUM    = 3'd4;
	localparam logic [STEP_W-1:0] ST_FB     = 3'd5;
	localparam logic [STEP_W-1:0] ST_COMMIT = 3'd6;

	typedef struct packed {
		logic [1:0] cond;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       term_ld;
		logic       y_ld;
		logic       commit;
		logic       last;
	} ctrl_t;

	// datapath strobes, already qualified by the handshakes
	typedef struct packed {
		logic       accept;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       term_ld;
		logic       y_ld;
		logic       commit;
	} op_t;

	function automatic ctrl_t fdlm_ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		case (step)
			ST_ACCEPT: begin
				c.cond = COND_IN;
			end
			ST_MIX_X: begin
				c.mul_en  = 1'b1;
				c.mul_sel = MUL_MIX_X;
			end
			ST_GAIN: begin
				c.term_ld = 1'b1;
				c.mul_en  = 1'b1;
				c.mul_sel = MUL_GAIN_DLY;
			end
			ST_COMP: begin
				c.mul_en  = 1'b1;
				c.mul_sel = MUL_COMP_SCL;
			end
			ST_SUM: begin
				c.y_ld = 1'b1;
			end
			ST_FB: begin
				c.mul_en  = 1'b1;
				c.mul_sel = MUL_FB_Y;
			end
			ST_COMMIT: begin
				c.cond   = COND_OUT;
				c.commit = 1'b1;
				c.last   = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

	function automatic logic signed [SW-1:0] sat16(input logic signed [SW:0] v);
		logic signed [SW-1:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	function automatic logic [CFW-1:0] clamp_coef(input logic [CFW-1:0] c);
		return (c > COEF_ONE) ? COEF_ONE : c;
	endfunction

endpackage

// File: design/fdlm_seq.sv
// ----------------------------------------------------------------------------
// fdlm_seq - microprogram sequencer
// Step counter over the control ROM; holds a step until its condition is met.
// ----------------------------------------------------------------------------
module fdlm_seq import fdlm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_free,
	output logic in_ready,
	output op_t  op
);

	logic [STEP_W-1:0] step_q;
	ctrl_t             ctrl;
	logic              advance;

	assign ctrl = fdlm_ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			COND_NONE: advance = 1'b1;
			COND_IN:   advance = in_valid;
			COND_OUT:  advance = out_free;
			default:   advance = 1'b1;
		endcase
	end

	assign in_ready   = (ctrl.cond == COND_IN);
	assign op.accept  = in_ready & in_valid;
	assign op.mul_en  = ctrl.mul_en;
	assign op.mul_sel = ctrl.mul_sel;
	assign op.term_ld = ctrl.term_ld;
	assign op.y_ld    = ctrl.y_ld;
	assign op.commit  = ctrl.commit & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_ACCEPT;
		end else if (advance) begin
			step_q <= ctrl.last ? ST_ACCEPT : step_q + 1'b1;
		end
	end

endmodule

// File: design/fdlm_dpath.sv
// ----------------------------------------------------------------------------
// fdlm_dpath - delay memory, shared multiplier and output register
// Runs the arithmetic of one sample under the strobes of the sequencer.
// ----------------------------------------------------------------------------
module fdlm_dpath import fdlm_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  op_t                   op,
	input  logic signed [SW-1:0]  sample_in,
	input  logic                  end_of_block,
	input  logic [$clog2(DEPTH)-1:0] delay,
	input  logic [CFW-1:0]        fb_coef,
	input  logic [CFW-1:0]        gain,
	input  logic [CFW-1:0]        mix,
	input  logic [CFW-1:0]        mix_comp,
	input  logic                  out_ready,
	output logic                  out_free,
	output logic                  out_valid,
	output logic signed [SW-1:0]  sample_out,
	output logic                  end_of_block_out
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic signed [SW-1:0] mem [DEPTH];

	logic [AW-1:0]        wp_q;
	logic                 wrapped_q;
	logic [AW:0]          diff;
	logic [AW:0]          rd_wide;
	logic [AW-1:0]        rd_addr;
	logic signed [SW-1:0] rd_data_q;
	logic                 rd_written_q;
	logic signed [SW-1:0] x_q;
	logic                 eob_q;
	logic signed [SW-1:0] dly;
	logic signed [31:0]   prod_q;
	logic signed [SW-1:0] prod_hi;
	logic signed [SW-1:0] term_q;
	logic signed [SW-1:0] y_q;
	logic [CFW-1:0]       coef_op;
	logic signed [SW-1:0] smp_op;
	logic signed [CFW:0]  coef_s;
	logic signed [33:0]   prod_full;
	logic signed [SW-1:0] stored;
	logic                 out_valid_q;
	logic signed [SW-1:0] sample_out_q;
	logic                 eob_out_q;

	// read address wraps below zero; entries at or past the write pointer before the
	// first wrap were never written and read as zero
	assign diff    = {1'b0, wp_q} - {1'b0, delay};
	assign rd_wide = diff[AW] ? diff + (AW+1)'(DEPTH) : diff;
	assign rd_addr = rd_wide[AW-1:0];

	assign dly     = rd_written_q ? rd_data_q : '0;
	assign prod_hi = prod_q[31:16];

	always_comb begin
		case (op.mul_sel)
			MUL_MIX_X: begin
				coef_op = mix;
				smp_op  = x_q;
			end
			MUL_GAIN_DLY: begin
				coef_op = gain;
				smp_op  = dly;
			end
			MUL_COMP_SCL: begin
				coef_op = mix_comp;
				smp_op  = prod_hi;
			end
			MUL_FB_Y: begin
				coef_op = fb_coef;
				smp_op  = y_q;
			end
			default: begin
				coef_op = '0;
				smp_op  = '0;
			end
		endcase
	end

	assign coef_s    = $signed({1'b0, coef_op});
	assign prod_full = coef_s * smp_op;
	assign stored    = sat16({x_q[SW-1], x_q} + {prod_hi[SW-1], prod_hi});

	always_ff @(posedge clk) begin
		if (op.commit) begin
			mem[wp_q] <= stored;
		end
	end

	always_ff @(posedge clk) begin
		if (op.accept) begin
			rd_data_q    <= mem[rd_addr];
			rd_written_q <= wrapped_q || (rd_addr < wp_q);
			x_q          <= sample_in;
			eob_q        <= end_of_block;
		end
		// products fit in 32 signed bits; floor by 2^16 is the upper half
		if (op.mul_en) begin
			prod_q <= prod_full[31:0];
		end
		if (op.term_ld) begin
			term_q <= prod_hi;
		end
		if (op.y_ld) begin
			y_q <= sat16({term_q[SW-1], term_q} + {prod_hi[SW-1], prod_hi});
		end
		if (op.commit) begin
			sample_out_q <= y_q;
			eob_out_q    <= eob_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op.commit) begin
				if (wp_q == AW'(DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (op.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free         = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign sample_out       = sample_out_q;
	assign end_of_block_out = eob_out_q;

endmodule

// File: design/feedback_delay_line_mixer_core.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_mixer_core - feedback echo with dry/wet mix
// Configuration registers, microprogram sequencer and datapath.
//
//   channel  signals                               beat
//   in       in_valid in_ready sample_in end_of_block   one input sample
//   out      out_valid out_ready sample_out end_of_block_out  one mixed sample
//   cfg      cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// A sample runs the 7-step control program, one step per cycle while no step
// waits on its handshake. Four steps share the single 18x16 multiplier. The
// result lands in the output register at the commit step, the last step of the
// program; the next sample is taken only after that commit.
// A result waiting on out_ready holds the final step only.
// No clearing pass after reset: a wrap flag marks which memory entries
// have been written, and unwritten entries read as zero.
// ----------------------------------------------------------------------------
module feedback_delay_line_mixer_core import fdlm_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [SW-1:0] sample_in,
	input  logic                 end_of_block,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [SW-1:0] sample_out,
	output logic                 end_of_block_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = ((AW > 16) ? AW : 16) + 1;
	localparam logic [AW-1:0] DLY_RST_C =
		(DLY_RST >= DEPTH) ? AW'(DEPTH - 1) : AW'(DLY_RST);

	logic [AW-1:0]  delay_q;
	logic [CFW-1:0] fb_q;
	logic [CFW-1:0] gain_q;
	logic [CFW-1:0] mix_q;
	logic [CFW-1:0] comp_q;
	logic [CFW-1:0] coef_w;
	logic [CW-1:0]  dly_w;
	op_t            op;
	logic           out_free;

	assign cfg_ready = 1'b1;
	assign coef_w    = clamp_coef(cfg_data);
	assign dly_w     = CW'(cfg_data[15:0]);

	// coefficients above one and delays past the memory are clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DLY_RST_C;
			fb_q    <= COEF_RST;
			gain_q  <= COEF_RST;
			mix_q   <= COEF_RST;
			comp_q  <= COEF_ONE - COEF_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DELAY: begin
					delay_q <= (dly_w >= CW'(DEPTH)) ? AW'(DEPTH - 1) : AW'(dly_w);
				end
				REG_FB: begin
					fb_q <= coef_w;
				end
				REG_GAIN: begin
					gain_q <= coef_w;
				end
				REG_MIX: begin
					mix_q  <= coef_w;
					comp_q <= COEF_ONE - coef_w;
				end
				default: begin
				end
			endcase
		end
	end

	fdlm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.op       (op)
	);

	fdlm_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.sample_in        (sample_in),
		.end_of_block     (end_of_block),
		.delay            (delay_q),
		.fb_coef          (fb_q),
		.gain             (gain_q),
		.mix              (mix_q),
		.mix_comp         (comp_q),
		.out_ready        (out_ready),
		.out_free         (out_free),
		.out_valid        (out_valid),
		.sample_out       (sample_out),
		.end_of_block_out (end_of_block_out)
	);

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench of feedback_delay_line_mixer_core
// Streams signed samples through the echo mixer under changing coefficient
// and delay settings and random handshake gaps. Each accepted sample is run
// through a local model of the delay memory, and each output beat is checked
// in order against it.
// ----------------------------------------------------------------------------
module tb;
	import fdlm_pkg::*;

	localparam int unsigned MEM_DEPTH = DEPTH_DEF;
	localparam longint      UNITY     = 65536;
	localparam int          MAX_SHOWN = 10;
	localparam int          PHASES    = 10;
	localparam int          PHASE_LEN = 115;
	localparam int          TAIL_CYC  = 12;

	localparam logic [CFG_IW-1:0] REG_SPARE_LO = 8'd4;
	localparam logic [CFG_IW-1:0] REG_SPARE_HI = 8'hFF;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 eob;
	} sample_beat_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	logic                 clk              = 1'b0;
	logic                 arst_n           = 1'b0;
	logic                 in_valid         = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] sample_in        = '0;
	logic                 end_of_block     = 1'b0;
	logic                 out_valid;
	logic                 out_ready        = 1'b0;
	logic signed [SW-1:0] sample_out;
	logic                 end_of_block_out;
	logic                 cfg_valid        = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IW-1:0]    cfg_index        = '0;
	logic [CFG_DW-1:0]    cfg_data         = '0;

	// local copy of the echo state and settings
	logic signed [SW-1:0] echo_mem [MEM_DEPTH];
	int unsigned          echo_wp;
	logic [15:0]          cur_delay;
	logic [CFW-1:0]       cur_fb;
	logic [CFW-1:0]       cur_gain;
	logic [CFW-1:0]       cur_mix;

	sample_beat_t pending_samples [$];
	sample_beat_t due_mixes [$];
	logic         took_sample = 1'b0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           n_sent = 0;
	int           n_mixed = 0;
	int           n_bad = 0;

	feedback_delay_line_mixer_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_in        (sample_in),
		.end_of_block     (end_of_block),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample_out       (sample_out),
		.end_of_block_out (end_of_block_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic signed [SW-1:0] clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[SW-1:0];
	endfunction

	function automatic longint unit_coef(input logic [CFW-1:0] c);
		return (c > UNITY) ? UNITY : longint'(c);
	endfunction

	// one sample through the echo: read, mix, write back, advance
	function automatic logic signed [SW-1:0] mix_echo(input logic signed [SW-1:0] x);
		int unsigned          off;
		int unsigned          rd;
		longint               x_l;
		longint               delayed;
		longint               scaled;
		longint               mixf;
		longint               wet;
		logic signed [SW-1:0] y;
		off = (cur_delay >= MEM_DEPTH) ? MEM_DEPTH - 1 : cur_delay;
		rd = (echo_wp + MEM_DEPTH - off) % MEM_DEPTH;
		x_l = longint'(x);
		delayed = longint'(echo_mem[rd]);
		// arithmetic shift of a signed product floors
		scaled = (delayed * unit_coef(cur_gain)) >>> 16;
		mixf = unit_coef(cur_mix);
		wet = ((mixf * x_l) >>> 16) + (((UNITY - mixf) * scaled) >>> 16);
		y = clip16(wet);
		echo_mem[echo_wp] = clip16(x_l + ((unit_coef(cur_fb) * longint'(y)) >>> 16));
		echo_wp = (echo_wp + 1) % MEM_DEPTH;
		return y;
	endfunction

	// monitor: track settings, predict on input beats, check output beats
	always @(posedge clk) begin : mon
		sample_beat_t want;
		took_sample <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY: cur_delay = cfg_data[15:0];
					REG_FB:    cur_fb    = cfg_data;
					REG_GAIN:  cur_gain  = cfg_data;
					REG_MIX:   cur_mix   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want.sample = mix_echo(sample_in);
				want.eob = end_of_block;
				due_mixes.push_back(want);
				n_sent++;
			end
			if (out_valid && out_ready) begin
				n_mixed++;
				if (due_mixes.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_SHOWN) begin
						$display("%0t: unexpected result sample_out=%0d eob=%0b",
							$realtime, sample_out, end_of_block_out);
					end
				end else begin
					want = due_mixes.pop_front();
					if (sample_out !== want.sample || end_of_block_out !== want.eob) begin
						n_bad++;
						if (n_bad <= MAX_SHOWN) begin
							$display("%0t: result %0d: sample_out exp %0d got %0d, eob exp %0b got %0b",
								$realtime, n_mixed, want.sample, sample_out,
								want.eob, end_of_block_out);
						end
					end
				end
			end
		end
	end

	// driver: present queued samples, hold a beat until it is taken
	always @(negedge clk) begin : drv
		sample_beat_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || took_sample) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_samples.pop_front();
					in_valid     <= 1'b1;
					sample_in    <= nxt.sample;
					end_of_block <= nxt.eob;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic set_idle(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 83;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 33;
				recv_stall_pct = 33;
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sample(input logic signed [SW-1:0] s, input logic eob);
		sample_beat_t b;
		b.sample = s;
		b.eob = eob;
		pending_samples.push_back(b);
	endtask

	// wait until every queued sample has come back, then let the pipe settle
	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || due_mixes.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYC) @(posedge clk);
	endtask

	function automatic logic [CFG_DW-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return COEF_ONE;
			2: return CFG_DW'($urandom_range(65537, 131071));
			default: return CFG_DW'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [15:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 3))
			1: return SW'($urandom_range(0, 4000) - 2000);
			2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return SW'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin : main
		for (int i = 0; i < MEM_DEPTH; i++) begin
			echo_mem[i] = '0;
		end
		echo_wp = 0;
		cur_delay = 16'(DLY_RST);
		cur_fb = COEF_RST;
		cur_gain = COEF_RST;
		cur_mix = COEF_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: field extremes against an empty memory
		set_idle(IDLE_NONE);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 1'b1);
		push_sample(16'sh0000, 1'b0);
		push_sample(-16'sd1, 1'b1);
		push_sample(16'sd1, 1'b0);
		push_sample(16'sh5555, 1'b0);
		push_sample(16'shAAAA, 1'b1);
		drain();

		// zero delay, fully wet, unity gain and feedback
		write_reg(REG_DELAY, 17'd0);
		write_reg(REG_FB, COEF_ONE);
		write_reg(REG_GAIN, COEF_ONE);
		write_reg(REG_MIX, 17'd0);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd12345, 1'b1);
		drain();

		// delay one with bit 16 set, coefficients above one: drive into saturation
		write_reg(REG_DELAY, 17'h10001);
		write_reg(REG_FB, 17'h1FFFF);
		write_reg(REG_GAIN, 17'h1FFFF);
		for (int i = 0; i < 6; i++) begin
			push_sample(16'sh7FFF, 1'b0);
		end
		for (int i = 0; i < 4; i++) begin
			push_sample(16'sh8000, i == 3);
		end
		drain();

		// writes to unknown indexes change nothing; mix above one is fully dry
		write_reg(REG_SPARE_LO, CFG_DW'($urandom_range(0, 131071)));
		write_reg(REG_SPARE_HI, 17'h1FFFF);
		write_reg(REG_MIX, 17'd65537);
		write_reg(REG_DELAY, 17'hFFFF);
		push_sample(16'sh7FFF, 1'b1);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd77, 1'b0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_idle(idle_mode_e'(ph % 4));
			write_reg(REG_DELAY, {1'($urandom), pick_delay()});
			write_reg(REG_FB, pick_coef());
			write_reg(REG_GAIN, pick_coef());
			write_reg(REG_MIX, pick_coef());
			if ($urandom_range(0, 2) == 0) begin
				write_reg(8'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					CFG_DW'($urandom_range(0, 131071)));
			end
			for (int i = 0; i < PHASE_LEN; i++) begin
				push_sample(pick_sample(), $urandom_range(0, 7) == 0);
			end
			drain();
		end

		$display("Covered %0d samples over %0d random setting phases plus directed cases;",
			n_sent, PHASES);
		$display("%0d mixed results compared, %0d mismatches.", n_mixed, n_bad);
		if (n_bad == 0 && due_mixes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("Timed out with %0d results still due.", due_mixes.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
design/fdlm_pkg.sv
design/fdlm_seq.sv
design/fdlm_dpath.sv
design/feedback_delay_line_mixer_core.sv
verif/tb.sv
